[hdl/kwise_polynomial_hash_rng_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the polynomial hash value generator
// Shared helpers that wrap a clocked implication with reset disable.
// ----------------------------------------------------------------------------
`ifndef KWISE_POLYNOMIAL_HASH_RNG_ASSERT_SVH
`define KWISE_POLYNOMIAL_HASH_RNG_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define KPH_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kph assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define KPH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kph assertion failed");

`endif

[hdl/kph_pkg.sv]
// ----------------------------------------------------------------------------
// Polynomial hash package
// Widths, codes, command types and helper functions shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kph_pkg;

  localparam int unsigned MAX_COEFS = 6;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned HALF_W    = DATA_W / 2;
  localparam int unsigned SHAMT_W   = $clog2(DATA_W);
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned WIDTH_W   = 7;
  localparam int unsigned REG_W     = 3;
  localparam int unsigned SEL_W     = $clog2(MAX_COEFS);

  // Opcodes of an input item; the fourth code is unused and ignored.
  localparam logic [1:0] OP_NEXT  = 2'd0;
  localparam logic [1:0] OP_AT    = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [REG_W-1:0] REG_COEF_0     = 3'd0;
  localparam logic [REG_W-1:0] REG_COEF_1     = 3'd1;
  localparam logic [REG_W-1:0] REG_COEF_5     = 3'd5;
  localparam logic [REG_W-1:0] REG_COEF_COUNT = 3'd6;
  localparam logic [REG_W-1:0] REG_WIDTH_BITS = 3'd7;

  localparam logic [CNT_W-1:0]   COEF_COUNT_RST = 3'd2;
  localparam logic [WIDTH_W-1:0] WIDTH_BITS_RST = 7'd32;

  typedef logic [DATA_W-1:0] word_t;
  typedef word_t [MAX_COEFS-1:0] coef_arr_t;

  // Coefficients after reset: the linear coefficient is one, all others zero.
  localparam coef_arr_t COEF_RST =
    {{((MAX_COEFS - 1) * DATA_W){1'b0}}, DATA_W'(1)} << (DATA_W * REG_COEF_1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LL,
    ST_LH,
    ST_HL,
    ST_FOLD,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_LOAD,
    DP_MUL_LL,
    DP_MUL_LH,
    DP_MUL_HL,
    DP_FOLD,
    DP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic             use_counter;
    logic             clr_cnt;
    logic             zero_acc;
    logic [SEL_W-1:0] coef_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Mask for arithmetic modulo 2^w; zero width gives modulus one.
  function automatic word_t width_mask(input logic [WIDTH_W-1:0] w);
    word_t m;
    if (w == '0) begin
      m = '0;
    end else if (w >= WIDTH_W'(DATA_W)) begin
      m = '1;
    end else begin
      m = ~({DATA_W{1'b1}} << w[SHAMT_W-1:0]);
    end
    return m;
  endfunction

  // Coefficient counts above the number of coefficient registers saturate.
  function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    return (c > CNT_W'(MAX_COEFS)) ? CNT_W'(MAX_COEFS) : c;
  endfunction

endpackage

`default_nettype wire

[hdl/kph_cfg.sv]
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the coefficients, the saturated term count and the modulus mask.
// ----------------------------------------------------------------------------
`default_nettype none

module kph_cfg
  import kph_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [REG_W-1:0]   cfg_index_i,
  input  logic [DATA_W-1:0]  cfg_data_i,
  output coef_arr_t          coefs_o,
  output logic [CNT_W-1:0]   terms_o,
  output word_t              mask_o
);

  coef_arr_t        coef_q;
  logic [CNT_W-1:0] terms_q;
  word_t            mask_q;

  assign cfg_ready_o = 1'b1;

  // The width register is kept only in its decoded form as a mask.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q  <= COEF_RST;
      terms_q <= COEF_COUNT_RST;
      mask_q  <= width_mask(WIDTH_BITS_RST);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i) inside
        [REG_COEF_0:REG_COEF_5]: coef_q[cfg_index_i] <= cfg_data_i;
        REG_COEF_COUNT:          terms_q <= sat_count(cfg_data_i[CNT_W-1:0]);
        REG_WIDTH_BITS:          mask_q  <= width_mask(cfg_data_i[WIDTH_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  assign coefs_o = coef_q;
  assign terms_o = terms_q;
  assign mask_o  = mask_q;

endmodule

`default_nettype wire

[hdl/kph_ctrl.sv]
// ----------------------------------------------------------------------------
// Evaluation controller
// Sequences the Horner steps and the three partial products of each step.
// ----------------------------------------------------------------------------
`default_nettype none

module kph_ctrl
  import kph_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       opcode_i,
  input  logic [CNT_W-1:0] terms_i,
  input  dp_status_t       status_i,
  output dp_cmd_t          cmd_o
);

  state_e           state_q, state_d;
  logic [SEL_W-1:0] idx_q, idx_d;
  logic             is_eval;

  assign is_eval = (opcode_i == OP_NEXT) || (opcode_i == OP_AT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // idx_q counts the coefficients still to be folded in by Horner steps.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && is_eval) begin
          idx_d   = SEL_W'(terms_i - CNT_W'(1));
          state_d = (terms_i > CNT_W'(1)) ? ST_LL : ST_DONE;
        end
      end
      ST_LL:   state_d = ST_LH;
      ST_LH:   state_d = ST_HL;
      ST_HL:   state_d = ST_FOLD;
      ST_FOLD: begin
        idx_d   = idx_q - SEL_W'(1);
        state_d = (idx_q == SEL_W'(1)) ? ST_DONE : ST_LL;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o.op          = DP_IDLE;
    cmd_o.use_counter = 1'b0;
    cmd_o.clr_cnt     = 1'b0;
    cmd_o.zero_acc    = 1'b0;
    cmd_o.coef_sel    = idx_q - SEL_W'(1);
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.coef_sel = SEL_W'(terms_i - CNT_W'(1));
        if (in_valid_i && is_eval) begin
          cmd_o.op          = DP_LOAD;
          cmd_o.use_counter = (opcode_i == OP_NEXT);
          cmd_o.zero_acc    = (terms_i == '0);
        end
        if (in_valid_i && (opcode_i == OP_CLEAR)) begin
          cmd_o.clr_cnt = 1'b1;
        end
      end
      ST_LL:   cmd_o.op = DP_MUL_LL;
      ST_LH:   cmd_o.op = DP_MUL_LH;
      ST_HL:   cmd_o.op = DP_MUL_HL;
      ST_FOLD: cmd_o.op = DP_FOLD;
      ST_DONE: cmd_o.op = status_i.out_free ? DP_OUT : DP_IDLE;
      default: cmd_o.op = DP_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[hdl/kph_dp.sv]
// ----------------------------------------------------------------------------
// Evaluation datapath
// Point counter, Horner accumulator on one 32x32 multiplier, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kph_dp
  import kph_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  input  logic [DATA_W-1:0] index_i,
  input  coef_arr_t         coefs_i,
  input  word_t             mask_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] value_o
);

  word_t             cnt_q;
  word_t             x_q;
  word_t             acc_q;
  word_t             sum_q;
  word_t             prod_q;
  word_t             value_q;
  logic              out_valid_q;
  word_t             coef_m;
  word_t             hi_sh;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  word_t             product;

  assign coef_m = ((cmd_i.coef_sel < SEL_W'(MAX_COEFS)) ? coefs_i[cmd_i.coef_sel] : '0)
                  & mask_i;
  assign hi_sh  = {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};

  // The low word of acc * x is LL + ((LH + HL) << 32); each partial product
  // is formed in its own state on the shared multiplier.
  always_comb begin
    case (cmd_i.op)
      DP_MUL_LL: begin
        mul_a = acc_q[HALF_W-1:0];
        mul_b = x_q[HALF_W-1:0];
      end
      DP_MUL_LH: begin
        mul_a = acc_q[HALF_W-1:0];
        mul_b = x_q[DATA_W-1:HALF_W];
      end
      DP_MUL_HL: begin
        mul_a = acc_q[DATA_W-1:HALF_W];
        mul_b = x_q[HALF_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = DATA_W'(mul_a) * DATA_W'(mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_cnt) begin
        cnt_q <= '0;
      end else if (cmd_i.op == DP_LOAD && cmd_i.use_counter) begin
        cnt_q <= ((cnt_q & mask_i) + DATA_W'(1)) & mask_i;
      end
      if (cmd_i.op == DP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        x_q   <= (cmd_i.use_counter ? cnt_q : index_i) & mask_i;
        acc_q <= cmd_i.zero_acc ? '0 : coef_m;
      end
      DP_MUL_LL: prod_q <= product;
      DP_MUL_LH: begin
        sum_q  <= prod_q + coef_m;
        prod_q <= product;
      end
      DP_MUL_HL: begin
        sum_q  <= sum_q + hi_sh;
        prod_q <= product;
      end
      DP_FOLD: acc_q   <= (sum_q + hi_sh) & mask_i;
      DP_OUT:  value_q <= acc_q;
      default: begin
      end
    endcase
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign value_o           = value_q;

endmodule

`default_nettype wire

[hdl/kwise_polynomial_hash_rng.sv]
// ----------------------------------------------------------------------------
// k-wise independent polynomial hash value generator
// Evaluates sum of coef_i * x^i modulo 2^width_bits at a counter or an index.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                Payload
//  -------  ---------  -----------------------  -------------------------------
//  cfg      in         cfg_valid_i/cfg_ready_o  cfg_index_i (3), cfg_data_i (64)
//  in       in         in_valid_i/in_ready_o    opcode_i (2), index_i (64)
//  out      out        out_valid_o/out_ready_i  value_o (64)
//
//  An evaluating item loads the highest coefficient in use, as set by the
//  saturated coefficient count, and then runs a Horner step for each lower
//  coefficient (none for a count of zero or one); each Horner step forms
//  three partial products on the shared 32x32 multiplier and then a fold.
//  The next item can be taken in the cycle after the result is loaded.
//  A clear or an ignored item leaves the controller idle and the input open.
//  Reset clears the point counter and loads the register reset values.
//  The input is taken only while the controller is idle. A finished result
//  waits in the controller until the output register is free, so a result
//  held at the output does not hold off the next item, but does hold off the
//  item after it.
//
`default_nettype none

module kwise_polynomial_hash_rng
  import kph_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write channel.
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [REG_W-1:0]  cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i,
  // Input items.
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [DATA_W-1:0] index_i,
  // Result items.
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] value_o
);

  coef_arr_t        coefs;
  logic [CNT_W-1:0] terms;
  word_t            mask;
  dp_cmd_t          cmd;
  dp_status_t       status;

  // The register file decodes the count and width at write time, so the
  // evaluation path sees a ready term count and modulus mask.
  kph_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coefs_o     (coefs),
    .terms_o     (terms),
    .mask_o      (mask)
  );

  // The controller accepts items, decodes the opcode and walks the
  // coefficients from the highest one in use down to the constant term.
  kph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .terms_i    (terms),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath evaluates by Horner's rule: acc = acc * x + coef, all
  // reduced by the modulus mask, which gives the same sum as the power form.
  kph_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .index_i     (index_i),
    .coefs_i     (coefs),
    .mask_i      (mask),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o)
  );

endmodule

`default_nettype wire

[hdl/kph_checker.sv]
// ----------------------------------------------------------------------------
// Port checker for the polynomial hash value generator
// Watches the top-level ports and flags sequencing errors.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kwise_polynomial_hash_rng_assert.svh"

module kph_checker
  import kph_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              cfg_valid_i,
  input wire logic              cfg_ready_o,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic [1:0]        opcode_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [DATA_W-1:0] value_o
);

  logic in_eval;
  logic in_other;

  assign in_eval  = in_valid_i && in_ready_o && (opcode_i == OP_NEXT || opcode_i == OP_AT);
  assign in_other = in_valid_i && in_ready_o && !(opcode_i == OP_NEXT || opcode_i == OP_AT);

  // A pending result holds its value until it is taken.
  `KPH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(value_o))

  // An evaluating item closes the input in the cycle after it is taken.
  `KPH_ASSERT_NEXT(a_eval_busy, clk_i, rst_ni, in_eval, !in_ready_o)

  // Clears and ignored items never close the input.
  `KPH_ASSERT_NEXT(a_other_ready, clk_i, rst_ni, in_other, in_ready_o)

  // A new result is only loaded at the end of an evaluation.
  `KPH_ASSERT_NOW(a_out_from_eval, clk_i, rst_ni, $rose(out_valid_o), !$past(in_ready_o))

  // The register file takes writes at any time.
  `KPH_ASSERT_NOW(a_cfg_open, clk_i, rst_ni, cfg_valid_i || !cfg_valid_i, cfg_ready_o)

endmodule

bind kwise_polynomial_hash_rng kph_checker u_kph_checker (.*);

`default_nettype wire
